>>> rtl/spvs_pkg.sv
package spvs_pkg;

  localparam int unsigned TempW  = 13;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned RegIdxW = 3;

  typedef enum logic [3:0] {
    ST_INIT1  = 4'd0,
    ST_INIT2  = 4'd1,
    ST_READY1 = 4'd2,
    ST_READY2 = 4'd3,
    ST_START1 = 4'd4,
    ST_START2 = 4'd5,
    ST_RUN1   = 4'd6,
    ST_RUN2   = 4'd7,
    ST_PAUSE1 = 4'd8,
    ST_PAUSE2 = 4'd9
  } spvs_state_e;

  typedef enum logic [RegIdxW-1:0] {
    REG_COLLECTOR_HIGH = 3'd0,
    REG_COLLECTOR_LOW  = 3'd1,
    REG_TANK_LIMIT     = 3'd2,
    REG_SHORT_DWELL    = 3'd3,
    REG_INIT_DWELL     = 3'd4,
    REG_STARTUP_DWELL  = 3'd5,
    REG_PAUSE_DWELL    = 3'd6
  } spvs_reg_e;

  typedef enum logic [1:0] {
    PUMP_OFF  = 2'd0,
    PUMP_FULL = 2'd1,
    PUMP_PID  = 2'd2
  } spvs_pump_e;

  localparam logic signed [TempW-1:0] CollectorHighRst = 13'sd960;
  localparam logic signed [TempW-1:0] CollectorLowRst  = 13'sd800;
  localparam logic signed [TempW-1:0] TankLimitRst     = 13'sd1360;
  localparam logic [TimeW-1:0]        ShortDwellRst    = 32'd10000;
  localparam logic [TimeW-1:0]        InitDwellRst     = 32'd30000;
  localparam logic [TimeW-1:0]        StartupDwellRst  = 32'd45000;
  localparam logic [TimeW-1:0]        PauseDwellRst    = 32'd480000;

  typedef struct packed {
    logic signed [TempW-1:0] collector_high;
    logic signed [TempW-1:0] collector_low;
    logic signed [TempW-1:0] tank_limit;
    logic [TimeW-1:0]        short_dwell;
    logic [TimeW-1:0]        init_dwell;
    logic [TimeW-1:0]        startup_dwell;
    logic [TimeW-1:0]        pause_dwell;
  } spvs_cfg_t;

  typedef struct packed {
    logic [TimeW-1:0]        now_ms;
    logic signed [TempW-1:0] collector_temp;
    logic signed [TempW-1:0] tank_temp;
    logic signed [TempW-1:0] return_temp;
  } spvs_sample_t;

  typedef struct packed {
    spvs_state_e next_state;
    logic        mark;
    logic        valve;
    spvs_pump_e  pump;
  } spvs_dec_t;

endpackage

>>> rtl/spvs_step.sv
module spvs_step import spvs_pkg::*; (
  input  spvs_state_e      state_i,
  input  logic [TimeW-1:0] dwell_mark_i,
  input  spvs_sample_t     sample_i,
  input  spvs_cfg_t        cfg_i,
  output spvs_dec_t        dec_o
);

  logic [TimeW-1:0] dwell;
  logic [TimeW-1:0] limit;
  logic             over;
  logic             ge;
  logic             c_lt_high, c_gt_high, c_lt_low, c_gt_low;
  logic             t_lt_lim, t_le_lim;

  assign dwell     = sample_i.now_ms - dwell_mark_i;
  assign ge        = sample_i.tank_temp >= sample_i.return_temp;
  assign c_lt_high = sample_i.collector_temp < cfg_i.collector_high;
  assign c_gt_high = sample_i.collector_temp > cfg_i.collector_high;
  assign c_lt_low  = sample_i.collector_temp < cfg_i.collector_low;
  assign c_gt_low  = sample_i.collector_temp > cfg_i.collector_low;
  assign t_lt_lim  = sample_i.tank_temp < cfg_i.tank_limit;
  assign t_le_lim  = sample_i.tank_temp <= cfg_i.tank_limit;

  // one dwell compare, limit picked per state
  always_comb begin
    limit = cfg_i.short_dwell;
    unique case (state_i)
      ST_INIT1: begin
        if (!c_lt_high) limit = cfg_i.init_dwell;
      end
      ST_START1, ST_START2: limit = cfg_i.startup_dwell;
      ST_PAUSE1, ST_PAUSE2: limit = cfg_i.pause_dwell;
      default: limit = cfg_i.short_dwell;
    endcase
  end

  assign over = dwell > limit;

  always_comb begin
    dec_o.next_state = state_i;
    dec_o.mark       = 1'b0;
    dec_o.valve      = state_i[0];
    dec_o.pump       = PUMP_OFF;
    unique case (state_i)
      ST_INIT1, ST_INIT2: begin
        if (c_lt_high) begin
          if ((state_i == ST_INIT1) ? !ge : ge) begin
            if (over) begin
              dec_o.next_state = (state_i == ST_INIT1) ? ST_INIT2 : ST_INIT1;
              dec_o.mark       = 1'b1;
            end
          end else begin
            dec_o.mark = 1'b1;
          end
        end else if (c_gt_high && over) begin
          dec_o.next_state = ge ? ST_READY1 : ST_READY2;
          dec_o.mark       = 1'b1;
        end
      end
      ST_READY1, ST_READY2: begin
        if (c_lt_low) begin
          dec_o.next_state = ge ? ST_INIT1 : ST_INIT2;
        end else if (t_lt_lim) begin
          if (over) begin
            dec_o.next_state = ge ? ST_START1 : ST_START2;
            dec_o.mark       = 1'b1;
          end
        end else if ((state_i == ST_READY1) ? !ge : ge) begin
          if (over) begin
            dec_o.next_state = (state_i == ST_READY1) ? ST_READY2 : ST_READY1;
            dec_o.mark       = 1'b1;
          end
        end else begin
          dec_o.mark = 1'b1;
        end
      end
      ST_START1, ST_START2: begin
        dec_o.pump = PUMP_FULL;
        if (over) begin
          dec_o.next_state = (state_i == ST_START1) ? ST_RUN1 : ST_RUN2;
          dec_o.mark       = 1'b1;
        end
      end
      ST_RUN1, ST_RUN2: begin
        dec_o.pump = PUMP_PID;
        if (c_gt_low && t_le_lim) begin
          if ((state_i == ST_RUN1) ? ge : !ge) begin
            dec_o.mark = 1'b1;
          end else if (over) begin
            dec_o.next_state = (state_i == ST_RUN1) ? ST_RUN2 : ST_RUN1;
            dec_o.mark       = 1'b1;
          end
        end else if (over) begin
          dec_o.next_state = ge ? ST_PAUSE1 : ST_PAUSE2;
          dec_o.mark       = 1'b1;
        end
      end
      ST_PAUSE1, ST_PAUSE2: begin
        if (over) begin
          dec_o.next_state = (state_i == ST_PAUSE1) ? ST_READY1 : ST_READY2;
          dec_o.mark       = 1'b1;
        end
      end
      default: begin
        dec_o.valve      = 1'b0;
        dec_o.next_state = ST_INIT1;
        dec_o.mark       = 1'b1;
      end
    endcase
  end

endmodule

>>> rtl/solar_pump_valve_sequencer_core.sv
// Path: an accepted input word loads the input register, then the step logic's
// decision loads the result register. Throughput: one word per cycle unless the
// result register is held by out_ready_i low; the step logic updates state and
// dwell mark as it loads the result register. Reset: state init1, dwell mark 0,
// thresholds and dwell times to defaults, both pipeline registers empty.
module solar_pump_valve_sequencer_core import spvs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [RegIdxW-1:0]      cfg_index_i,
  input  logic [TimeW-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [TimeW-1:0]        now_ms_i,
  input  logic signed [TempW-1:0] collector_temp_i,
  input  logic signed [TempW-1:0] tank_temp_i,
  input  logic signed [TempW-1:0] return_temp_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [3:0]              state_code_o,
  output logic                    valve_open_o,
  output logic [1:0]              pump_mode_o,
  output logic                    entered_o
);

  spvs_cfg_t        cfg_q;
  spvs_sample_t     sample_q;
  logic             s1_valid_q;
  logic             s1_adv;
  spvs_state_e      state_q;
  logic [TimeW-1:0] mark_q;
  spvs_dec_t        dec;
  logic             out_valid_q;
  spvs_state_e      out_state_q;
  logic             out_valve_q;
  spvs_pump_e       out_pump_q;
  logic             out_entered_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.collector_high <= CollectorHighRst;
      cfg_q.collector_low  <= CollectorLowRst;
      cfg_q.tank_limit     <= TankLimitRst;
      cfg_q.short_dwell    <= ShortDwellRst;
      cfg_q.init_dwell     <= InitDwellRst;
      cfg_q.startup_dwell  <= StartupDwellRst;
      cfg_q.pause_dwell    <= PauseDwellRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_COLLECTOR_HIGH: cfg_q.collector_high <= cfg_data_i[TempW-1:0];
        REG_COLLECTOR_LOW:  cfg_q.collector_low  <= cfg_data_i[TempW-1:0];
        REG_TANK_LIMIT:     cfg_q.tank_limit     <= cfg_data_i[TempW-1:0];
        REG_SHORT_DWELL:    cfg_q.short_dwell    <= cfg_data_i;
        REG_INIT_DWELL:     cfg_q.init_dwell     <= cfg_data_i;
        REG_STARTUP_DWELL:  cfg_q.startup_dwell  <= cfg_data_i;
        REG_PAUSE_DWELL:    cfg_q.pause_dwell    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sample_q.now_ms         <= now_ms_i;
      sample_q.collector_temp <= collector_temp_i;
      sample_q.tank_temp      <= tank_temp_i;
      sample_q.return_temp    <= return_temp_i;
    end
  end

  spvs_step u_step (
    .state_i      (state_q),
    .dwell_mark_i (mark_q),
    .sample_i     (sample_q),
    .cfg_i        (cfg_q),
    .dec_o        (dec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT1;
      mark_q  <= '0;
    end else if (s1_adv) begin
      state_q <= dec.next_state;
      if (dec.mark) mark_q <= sample_q.now_ms;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_state_q   <= dec.next_state;
      out_valve_q   <= dec.valve;
      out_pump_q    <= dec.pump;
      out_entered_q <= (dec.next_state != state_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign state_code_o = out_state_q;
  assign valve_open_o = out_valve_q;
  assign pump_mode_o  = out_pump_q;
  assign entered_o    = out_entered_q;

  a_state_tracks_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> state_q == out_state_q)
    else $error("state register differs from last result word");

  a_no_accept_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while both stages are stalled");

  a_hold_without_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && (dec.next_state == state_q) |=> !entered_o && $stable(state_q))
    else $error("entered flag or state changed without a transition");

endmodule
